// File: hw/rtl/bmpm_pkg.sv
// Shared types, codes and constants of the banked memory page mapper.
// Depends on nothing; every other file of the block but bmpm_channels refers to it by scoped names.
`default_nettype none

package bmpm_pkg;

   // Request codes as carried on the request channel.
   localparam logic [2:0] REQ_MEM_READ   = 3'd0;
   localparam logic [2:0] REQ_MEM_WRITE  = 3'd1;
   localparam logic [2:0] REQ_PORT_READ  = 3'd2;
   localparam logic [2:0] REQ_PORT_WRITE = 3'd3;
   localparam logic [2:0] REQ_IPL_RESET  = 3'd4;

   // Decoded I/O ports.
   localparam logic [7:0] PORT_MAP_POINTER = 8'hB4;
   localparam logic [7:0] PORT_MAP_DATA    = 8'hB5;
   localparam logic [7:0] PORT_DICT_BANK   = 8'hCE;
   localparam logic [7:0] PORT_KANJI_BANK  = 8'hCF;

   // Read value of a port that nothing decodes.
   localparam logic [7:0] PORT_UNDECODED = 8'hFF;

   // Page code ranges.
   localparam logic [5:0] PAGE_RAM_LAST   = 6'h1F;
   localparam logic [5:0] PAGE_VRAM_FIRST = 6'h20;
   localparam logic [5:0] PAGE_VRAM_LAST  = 6'h2F;
   localparam logic [5:0] PAGE_CRTC_FIRST = 6'h30;
   localparam logic [5:0] PAGE_CRTC_LAST  = 6'h33;
   localparam logic [5:0] PAGE_IPL_FIRST  = 6'h34;
   localparam logic [5:0] PAGE_IPL_LAST   = 6'h37;
   localparam logic [5:0] PAGE_TVRAM      = 6'h38;
   localparam logic [5:0] PAGE_KANJI      = 6'h39;
   localparam logic [5:0] PAGE_DICT       = 6'h3A;
   localparam logic [5:0] PAGE_PHONE_FIRST = 6'h3C;
   localparam logic [5:0] PAGE_PHONE_LAST  = 6'h3F;

   // Page geometry.
   localparam int PAGE_BITS  = 13;
   localparam int PAGES      = 8;
   localparam int INDEX_BITS = $clog2(PAGES);

   // Wait counts.
   localparam logic [1:0] WAIT_NONE  = 2'd0;
   localparam logic [1:0] WAIT_SHORT = 2'd1;
   localparam logic [1:0] WAIT_LONG  = 2'd2;

   typedef enum logic [3:0] {
      TARGET_RAM   = 4'd0,
      TARGET_VRAM  = 4'd1,
      TARGET_CRTC  = 4'd2,
      TARGET_IPL   = 4'd3,
      TARGET_TVRAM = 4'd4,
      TARGET_PCG   = 4'd5,
      TARGET_KANJI = 4'd6,
      TARGET_DICT  = 4'd7,
      TARGET_PHONE = 4'd8,
      TARGET_NONE  = 4'd9
   } target_type;

   // One item held between the input register and the result register.
   typedef struct packed {
      logic [2:0]            req_code;
      logic [15:0]           address;
      logic [INDEX_BITS-1:0] pointer;
   } stage_item_type;

   // Bank registers seen by the translation.
   typedef struct packed {
      logic [4:0] dict;
      logic [7:0] kanji;
   } bank_type;

   // Write request to the page table.
   typedef struct packed {
      logic                  enable;
      logic [INDEX_BITS-1:0] index;
      logic [5:0]            code;
   } table_write_type;

   // One result item.
   typedef struct packed {
      target_type  target;
      logic [17:0] offset;
      logic        write_enable;
      logic [1:0]  wait_cycles;
      logic [7:0]  port_data;
   } rsp_item_type;

   // Page code that the IPL reset loads into a given entry.
   function automatic logic [5:0] ipl_code(input logic [INDEX_BITS-1:0] index);
      logic [5:0] code;
      if (index[2]) begin
         code = 6'(index);
      end else begin
         code = PAGE_IPL_FIRST | 6'(index[1:0]);
      end
      return code;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bmpm_channels.sv
// Handshake channels of the page mapper: request and response interfaces.
// Depends on nothing but the port widths of the block.
`default_nettype none

interface bmpm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [15:0] address;
   logic [7:0]  data;

   modport source (output valid, output req_type, output address, output data,
                   input ready);
   modport sink (input valid, input req_type, input address, input data,
                 output ready);
   modport monitor (input valid, input ready, input req_type, input address,
                    input data);
endinterface

interface bmpm_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  target;
   logic [17:0] offset;
   logic        write_enable;
   logic [1:0]  wait_cycles;
   logic [7:0]  port_data;

   modport source (output valid, output target, output offset, output write_enable,
                   output wait_cycles, output port_data, input ready);
   modport sink (input valid, input target, input offset, input write_enable,
                 input wait_cycles, input port_data, output ready);
   modport monitor (input valid, input ready, input target, input offset,
                    input write_enable, input wait_cycles, input port_data);
endinterface

`default_nettype wire

// File: hw/rtl/bmpm_page_table.sv
// Page table: eight 6-bit page codes, one write port, a parallel IPL load and two registered
// read ports. Depends on bmpm_pkg for the write request type, the IPL codes and the index width.
`default_nettype none

module bmpm_page_table (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bmpm_pkg::table_write_type      wr,
   input  wire logic                           ipl_load,
   input  wire logic                           rd_enable,
   input  wire logic [bmpm_pkg::INDEX_BITS-1:0] rd_page_index,
   input  wire logic [bmpm_pkg::INDEX_BITS-1:0] rd_ptr_index,
   output logic [5:0]                          rd_page_code,
   output logic [5:0]                          rd_ptr_code
);

   logic [5:0] code_mem [bmpm_pkg::PAGES];
   logic [bmpm_pkg::PAGES-1:0] valid_ff;
   logic [5:0] rd_page_ff;
   logic [5:0] rd_ptr_ff;

   // Storage write: either the whole IPL map at once or one code at the pointer.
   always_ff @(posedge clock) begin
      if (ipl_load) begin
         for (int i = 0; i < bmpm_pkg::PAGES; i++) begin
            code_mem[i] <= bmpm_pkg::ipl_code(bmpm_pkg::INDEX_BITS'(i));
         end
      end else if (wr.enable) begin
         code_mem[wr.index] <= wr.code;
      end
   end

   // An entry that was never written reads as its own index.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ipl_load) begin
         valid_ff <= '1;
      end else if (wr.enable) begin
         valid_ff[wr.index] <= 1'b1;
      end
   end

   // Registered reads; a write in the same cycle is seen only afterwards.
   always_ff @(posedge clock) begin
      if (rd_enable) begin
         rd_page_ff <= valid_ff[rd_page_index] ? code_mem[rd_page_index]
                                               : 6'(rd_page_index);
         rd_ptr_ff  <= valid_ff[rd_ptr_index] ? code_mem[rd_ptr_index]
                                              : 6'(rd_ptr_index);
      end
   end

   assign rd_page_code = rd_page_ff;
   assign rd_ptr_code  = rd_ptr_ff;

endmodule

`default_nettype wire

// File: hw/rtl/bmpm_translate.sv
// Result decode: turns a staged item, its page codes and the banks into a result item.
// Depends on bmpm_pkg for codes, ranges and structure types.
`default_nettype none

module bmpm_translate (
   input  wire bmpm_pkg::stage_item_type item,
   input  wire logic [5:0]               page_code,
   input  wire logic [5:0]               ptr_code,
   input  wire bmpm_pkg::bank_type       banks,
   output bmpm_pkg::rsp_item_type        result
);

   logic [bmpm_pkg::PAGE_BITS-1:0] low;
   logic [7:0]                     port;
   logic [3:0]                     swz;
   logic                           wr;

   assign low  = item.address[bmpm_pkg::PAGE_BITS-1:0];
   assign port = item.address[7:0];
   assign wr   = (item.req_code == bmpm_pkg::REQ_MEM_WRITE);
   // Video RAM plane swizzle of the low nibble of the code.
   assign swz  = {page_code[2], page_code[1], page_code[3], page_code[0]};

   always_comb begin
      result.target       = bmpm_pkg::TARGET_NONE;
      result.offset       = '0;
      result.write_enable = 1'b0;
      result.wait_cycles  = bmpm_pkg::WAIT_NONE;
      result.port_data    = '0;

      unique case (item.req_code)
         bmpm_pkg::REQ_MEM_READ, bmpm_pkg::REQ_MEM_WRITE: begin
            // Memory access: the page code selects the region.
            case (page_code) inside
               [6'h00:bmpm_pkg::PAGE_RAM_LAST]: begin
                  result.target       = bmpm_pkg::TARGET_RAM;
                  result.offset       = {page_code[4:0], low};
                  result.write_enable = wr;
               end
               [bmpm_pkg::PAGE_VRAM_FIRST:bmpm_pkg::PAGE_VRAM_LAST]: begin
                  result.target       = bmpm_pkg::TARGET_VRAM;
                  result.offset       = {1'b0, swz, low};
                  result.write_enable = wr;
                  result.wait_cycles  = bmpm_pkg::WAIT_SHORT;
               end
               [bmpm_pkg::PAGE_CRTC_FIRST:bmpm_pkg::PAGE_CRTC_LAST]: begin
                  result.target       = bmpm_pkg::TARGET_CRTC;
                  result.offset       = {3'b000, page_code[1:0], low};
                  result.write_enable = wr;
                  result.wait_cycles  = bmpm_pkg::WAIT_LONG;
               end
               [bmpm_pkg::PAGE_IPL_FIRST:bmpm_pkg::PAGE_IPL_LAST]: begin
                  result.target = bmpm_pkg::TARGET_IPL;
                  result.offset = {3'b000, page_code[1:0], low};
               end
               bmpm_pkg::PAGE_TVRAM: begin
                  // The top quarter of the text page reaches nothing.
                  result.wait_cycles = bmpm_pkg::WAIT_SHORT;
                  if (low[12:11] != 2'b11) begin
                     result.target       = bmpm_pkg::TARGET_TVRAM;
                     result.offset       = {5'b00000, low};
                     result.write_enable = wr;
                  end
               end
               bmpm_pkg::PAGE_KANJI: begin
                  // With the kanji bank enabled the first 2 KB read kanji ROM.
                  result.wait_cycles = bmpm_pkg::WAIT_LONG;
                  if (banks.kanji[7] && (low[12:11] == 2'b00)) begin
                     result.target = bmpm_pkg::TARGET_KANJI;
                     result.offset = {banks.kanji[6:0], low[10:0]};
                  end else begin
                     result.target       = bmpm_pkg::TARGET_PCG;
                     result.offset       = {5'b00000, low};
                     result.write_enable = wr;
                  end
               end
               bmpm_pkg::PAGE_DICT: begin
                  result.target = bmpm_pkg::TARGET_DICT;
                  result.offset = {banks.dict, low};
               end
               [bmpm_pkg::PAGE_PHONE_FIRST:bmpm_pkg::PAGE_PHONE_LAST]: begin
                  result.target = bmpm_pkg::TARGET_PHONE;
                  result.offset = {3'b000, page_code[1:0], low};
               end
               default: begin
                  result.target = bmpm_pkg::TARGET_NONE;
               end
            endcase
         end
         bmpm_pkg::REQ_PORT_READ: begin
            // Port read: pointer, the entry at the pointer, or all ones.
            if (port == bmpm_pkg::PORT_MAP_POINTER) begin
               result.port_data = 8'(item.pointer);
            end else if (port == bmpm_pkg::PORT_MAP_DATA) begin
               result.port_data = {2'b00, ptr_code};
            end else begin
               result.port_data = bmpm_pkg::PORT_UNDECODED;
            end
         end
         default: begin
            result.port_data = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/banked_memory_page_mapper_unit.sv
// Top level of the banked memory page mapper: control, pointer, banks, result register.
// Depends on bmpm_pkg, bmpm_channels, bmpm_page_table and bmpm_translate.
//
//   channel | dir | payload                                            | handshake
//   --------+-----+----------------------------------------------------+----------
//   req_ch  | in  | req_type, address, data                            | valid/ready
//   rsp_ch  | out | target, offset, write_enable, wait_cycles, port_data | valid/ready
//
// One item is taken per cycle while the response side is not stalled; its result is held first
// behind the page table's registered read and the staging register, then in the result register.
// An IPL reset item loads all eight page table entries at the edge that accepts it.
// Reset is synchronous and clears the pointer, the banks and the entry valid bits.
// A stalled response holds one item in the result register and one in the staging
// register; acceptance resumes as soon as the response side takes an item.
`default_nettype none

module banked_memory_page_mapper_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   bmpm_req_if.sink    req_ch,
   bmpm_rsp_if.source  rsp_ch
);

   localparam int IB = bmpm_pkg::INDEX_BITS;

   logic                    req_accept;
   logic [7:0]              port;
   logic                    out_free;
   logic                    s1_move;
   logic                    s1_free;

   logic                    s1_valid_ff, s1_valid_in;
   bmpm_pkg::stage_item_type s1_item_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   bmpm_pkg::rsp_item_type  rsp_item_ff;
   bmpm_pkg::rsp_item_type  result;

   logic [IB-1:0]           pointer_ff, pointer_in;
   bmpm_pkg::bank_type      banks_ff, banks_in;

   bmpm_pkg::table_write_type table_wr;
   logic                    ipl_load;
   logic [5:0]              page_code;
   logic [5:0]              ptr_code;

   // Flow control through the staging and result registers.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_move      = s1_valid_ff && out_free;
   assign s1_free      = !s1_valid_ff || s1_move;
   assign req_ch.ready = s1_free;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign port         = req_ch.address[7:0];

   // Pointer and bank updates for port writes, port reads and IPL reset.
   always_comb begin
      pointer_in = pointer_ff;
      banks_in   = banks_ff;
      if (req_accept) begin
         unique case (req_ch.req_type)
            bmpm_pkg::REQ_PORT_READ: begin
               if (port == bmpm_pkg::PORT_MAP_DATA) begin
                  pointer_in = pointer_ff + 1'b1;
               end
            end
            bmpm_pkg::REQ_PORT_WRITE: begin
               if (port == bmpm_pkg::PORT_MAP_POINTER) begin
                  pointer_in = req_ch.data[IB-1:0];
               end else if (port == bmpm_pkg::PORT_MAP_DATA) begin
                  pointer_in = pointer_ff + 1'b1;
               end else if (port == bmpm_pkg::PORT_DICT_BANK) begin
                  banks_in.dict = req_ch.data[4:0];
               end else if (port == bmpm_pkg::PORT_KANJI_BANK) begin
                  banks_in.kanji = req_ch.data;
               end
            end
            bmpm_pkg::REQ_IPL_RESET: begin
               // The IPL load leaves the pointer back at zero.
               pointer_in = '0;
            end
            default: begin
               pointer_in = pointer_ff;
            end
         endcase
      end
   end

   // Page table write: the whole IPL map, or a code loaded at the pointer.
   assign ipl_load = req_accept && (req_ch.req_type == bmpm_pkg::REQ_IPL_RESET);

   always_comb begin
      table_wr.enable = 1'b0;
      table_wr.index  = pointer_ff;
      table_wr.code   = req_ch.data[5:0];
      if (req_accept && (req_ch.req_type == bmpm_pkg::REQ_PORT_WRITE)
          && (port == bmpm_pkg::PORT_MAP_DATA)) begin
         table_wr.enable = 1'b1;
      end
   end

   bmpm_page_table u_page_table (
      .clock         (clock),
      .reset         (reset),
      .wr            (table_wr),
      .ipl_load      (ipl_load),
      .rd_enable     (req_accept),
      .rd_page_index (req_ch.address[15:13]),
      .rd_ptr_index  (pointer_ff),
      .rd_page_code  (page_code),
      .rd_ptr_code   (ptr_code)
   );

   bmpm_translate u_translate (
      .item      (s1_item_ff),
      .page_code (page_code),
      .ptr_code  (ptr_code),
      .banks     (banks_ff),
      .result    (result)
   );

   // Control state.
   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         pointer_ff      <= '0;
         banks_ff        <= '0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         pointer_ff      <= pointer_in;
         banks_ff        <= banks_in;
      end
   end

   // Staging and result payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff.req_code <= req_ch.req_type;
         s1_item_ff.address  <= req_ch.address;
         s1_item_ff.pointer  <= pointer_ff;
      end
      if (s1_move) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.target       = rsp_item_ff.target;
   assign rsp_ch.offset       = rsp_item_ff.offset;
   assign rsp_ch.write_enable = rsp_item_ff.write_enable;
   assign rsp_ch.wait_cycles  = rsp_item_ff.wait_cycles;
   assign rsp_ch.port_data    = rsp_item_ff.port_data;

endmodule

`default_nettype wire

// File: hw/rtl/bmpm_checker.sv
// Port-level checks of the page mapper, attached to the top level by a bind.
// Depends on bmpm_pkg and the top level's channel signals.
`default_nettype none

module bmpm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  rsp_target,
   input wire logic [17:0] rsp_offset,
   input wire logic        rsp_write_enable,
   input wire logic [1:0]  rsp_wait_cycles,
   input wire logic [7:0]  rsp_port_data
);

   // A stalled result item holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_target) && $stable(rsp_offset)
          && $stable(rsp_write_enable) && $stable(rsp_wait_cycles)
          && $stable(rsp_port_data)))
      else $error("stalled result item changed");

   // The cycle after a reset shows no result item.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item valid straight after reset");

   // A write is only enabled towards a writable region.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_write_enable) |->
         ((rsp_target == bmpm_pkg::TARGET_RAM) || (rsp_target == bmpm_pkg::TARGET_VRAM)
          || (rsp_target == bmpm_pkg::TARGET_CRTC) || (rsp_target == bmpm_pkg::TARGET_TVRAM)
          || (rsp_target == bmpm_pkg::TARGET_PCG)))
      else $error("write enabled towards a read-only region");

   // With the output stalled and a second item taken, both registers are full.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && req_valid && req_ready)
         |=> (!req_ready || rsp_ready))
      else $error("item accepted with no room left");

endmodule

bind banked_memory_page_mapper_unit bmpm_checker u_bmpm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_target       (rsp_ch.target),
   .rsp_offset       (rsp_ch.offset),
   .rsp_write_enable (rsp_ch.write_enable),
   .rsp_wait_cycles  (rsp_ch.wait_cycles),
   .rsp_port_data    (rsp_ch.port_data)
);

`default_nettype wire
